>>> hw/rtl/plr_pkg.sv
// Shared types, constants and helpers for the page-mode line rasterizer.
`timescale 1ns / 1ps

package plr_pkg;

    localparam int COORD_W      = 7;
    localparam int PAGE_W       = 4;
    localparam int PIX_W        = 8;
    localparam int ERR_W        = 10;
    localparam int TWICE_W      = 8;
    localparam int PAGE_SHIFT   = 3;
    localparam int DEF_ROW_BITS = 7;
    localparam int DEF_COL_BITS = 7;
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

    localparam logic OP_START  = 1'b0;
    localparam logic OP_STEP   = 1'b1;
    localparam logic KIND_POS  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_INC  = 2'd1,
        DIR_DEC  = 2'd2
    } t_dir;

    typedef struct packed {
        logic              kind;
        logic [PAGE_W-1:0] page;
        logic [COORD_W-1:0] column;
        logic [PIX_W-1:0]  pixels;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic t_result f_pos(input logic [PAGE_W-1:0] page,
                                      input logic [COORD_W-1:0] column);
        t_result r;
        r.kind   = KIND_POS;
        r.page   = page;
        r.column = column;
        r.pixels = '0;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic t_result f_data(input logic [PIX_W-1:0] pixels,
                                       input logic last);
        t_result r;
        r.kind   = KIND_DATA;
        r.page   = '0;
        r.column = '0;
        r.pixels = pixels;
        r.last   = last;
        return r;
    endfunction

endpackage

>>> hw/rtl/page_mode_line_rasterizer.sv
// Top level of the page-mode Bresenham line rasterizer.
`timescale 1ns / 1ps

// Draws lines for a display whose memory holds vertical 8-pixel bytes per
// page and column. A start transaction (opcode 0) emits a set-position result;
// each step transaction (opcode 1) advances one pixel and emits nothing, or a
// data byte followed by a new position when the column or page changes; the
// step after the last pixel emits the final byte with last set. Steps while no
// line is open are dropped. One transaction is accepted per cycle unless
// input is held off; it is registered in the input register, then its
// results enter a 4-entry result queue. Results leave at one per cycle
// while the output is ready. A transaction in the input register waits
// while the queue has fewer than two free slots, so a long run of page or
// column crossings is paced by the results leaving the queue.

module page_mode_line_rasterizer import plr_pkg::*; #(
    parameter int ROW_BITS = DEF_ROW_BITS,
    parameter int COL_BITS = DEF_COL_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_opcode,
    input  logic [COORD_W-1:0] i_row_start,
    input  logic [COORD_W-1:0] i_col_start,
    input  logic [COORD_W-1:0] i_row_end,
    input  logic [COORD_W-1:0] i_col_end,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_kind,
    output logic [PAGE_W-1:0]  o_page,
    output logic [COORD_W-1:0] o_column,
    output logic [PIX_W-1:0]   o_pixels,
    output logic               o_last
);

    t_push   push;
    t_result result;
    logic    room;

    plr_step #(
        .ROW_BITS (ROW_BITS),
        .COL_BITS (COL_BITS)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_row_start (i_row_start),
        .i_col_start (i_col_start),
        .i_row_end   (i_row_end),
        .i_col_end   (i_col_end),
        .i_room      (room),
        .o_push      (push)
    );

    plr_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_kind   = result.kind;
    assign o_page   = result.page;
    assign o_column = result.column;
    assign o_pixels = result.pixels;
    assign o_last   = result.last;

endmodule

>>> hw/rtl/plr_step.sv
// Input register, line state and one Bresenham step per transaction.
`timescale 1ns / 1ps

module plr_step import plr_pkg::*; #(
    parameter int ROW_BITS = DEF_ROW_BITS,
    parameter int COL_BITS = DEF_COL_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_opcode,
    input  logic [COORD_W-1:0] i_row_start,
    input  logic [COORD_W-1:0] i_col_start,
    input  logic [COORD_W-1:0] i_row_end,
    input  logic [COORD_W-1:0] i_col_end,
    input  logic               i_room,
    output t_push              o_push
);

    logic               r_in_valid;
    logic               r_opcode;
    logic [COORD_W-1:0] r_row_start, r_col_start, r_row_end, r_col_end;

    logic                r_active, n_active;
    logic [ROW_BITS-1:0] r_cur_row, n_cur_row;
    logic [COL_BITS-1:0] r_cur_col, n_cur_col;
    t_dir                r_row_dir, n_row_dir;
    t_dir                r_col_dir, n_col_dir;
    logic                r_major_is_col, n_major_is_col;
    logic [ERR_W-1:0]    r_err, n_err;
    logic [TWICE_W-1:0]  r_minor_twice, n_minor_twice;
    logic [TWICE_W-1:0]  r_major_twice, n_major_twice;
    logic [COORD_W-1:0]  r_steps_left, n_steps_left;
    logic [PIX_W-1:0]    r_pixel_byte, n_pixel_byte;

    logic                fire;
    logic [ROW_BITS-1:0] r0, r1, adr, st_row;
    logic [COL_BITS-1:0] c0, c1, adc, st_col;
    logic [COORD_W-1:0]  adr_x, adc_x, major, minor;
    logic                e_ge;

    function automatic logic [ROW_BITS-1:0] f_move_row(input logic [ROW_BITS-1:0] v,
                                                       input t_dir d);
        logic [ROW_BITS-1:0] r;
        unique case (d)
            DIR_INC: r = v + ROW_BITS'(1);
            DIR_DEC: r = v - ROW_BITS'(1);
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic [COL_BITS-1:0] f_move_col(input logic [COL_BITS-1:0] v,
                                                       input t_dir d);
        logic [COL_BITS-1:0] r;
        unique case (d)
            DIR_INC: r = v + COL_BITS'(1);
            DIR_DEC: r = v - COL_BITS'(1);
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic [PAGE_W-1:0] f_page(input logic [ROW_BITS-1:0] row);
        logic [COORD_W-1:0] wide;
        wide = COORD_W'(row);
        return wide[COORD_W-1:PAGE_SHIFT];
    endfunction

    function automatic logic [PIX_W-1:0] f_bit(input logic [ROW_BITS-1:0] row);
        return PIX_W'(1) << row[PAGE_SHIFT-1:0];
    endfunction

    assign fire       = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || fire;

    always_comb begin
        r0 = r_row_start[ROW_BITS-1:0];
        r1 = r_row_end[ROW_BITS-1:0];
        c0 = r_col_start[COL_BITS-1:0];
        c1 = r_col_end[COL_BITS-1:0];
        adr = (r1 > r0) ? r1 - r0 : r0 - r1;
        adc = (c1 > c0) ? c1 - c0 : c0 - c1;
        adr_x = COORD_W'(adr);
        adc_x = COORD_W'(adc);
        e_ge  = !r_err[ERR_W-1];
        major = (adr_x < adc_x) ? adc_x : adr_x;
        minor = (adr_x < adc_x) ? adr_x : adc_x;
        st_row = r_cur_row;
        st_col = r_cur_col;

        n_active       = r_active;
        n_cur_row      = r_cur_row;
        n_cur_col      = r_cur_col;
        n_row_dir      = r_row_dir;
        n_col_dir      = r_col_dir;
        n_major_is_col = r_major_is_col;
        n_err          = r_err;
        n_minor_twice  = r_minor_twice;
        n_major_twice  = r_major_twice;
        n_steps_left   = r_steps_left;
        n_pixel_byte   = r_pixel_byte;
        o_push.count   = 2'd0;
        o_push.res0    = f_data(r_pixel_byte, 1'b0);
        o_push.res1    = f_pos(f_page(r_cur_row), COORD_W'(r_cur_col));

        if (fire) begin
            if (r_opcode == OP_START) begin
                n_row_dir      = (r1 > r0) ? DIR_INC : ((r1 < r0) ? DIR_DEC : DIR_NONE);
                n_col_dir      = (c1 > c0) ? DIR_INC : ((c1 < c0) ? DIR_DEC : DIR_NONE);
                n_major_is_col = adr_x < adc_x;
                n_minor_twice  = {minor, 1'b0};
                n_major_twice  = {major, 1'b0};
                n_err          = ERR_W'({minor, 1'b0}) - ERR_W'(major);
                n_steps_left   = major;
                n_cur_row      = r0;
                n_cur_col      = c0;
                n_pixel_byte   = f_bit(r0);
                n_active       = 1'b1;
                o_push.count   = 2'd1;
                o_push.res0    = f_pos(f_page(r0), COORD_W'(c0));
            end else if (r_active) begin
                if (r_steps_left == '0) begin
                    n_active     = 1'b0;
                    o_push.count = 2'd1;
                    o_push.res0  = f_data(r_pixel_byte, 1'b1);
                end else begin
                    if (r_major_is_col) begin
                        st_col = f_move_col(r_cur_col, r_col_dir);
                        if (e_ge) begin
                            st_row = f_move_row(r_cur_row, r_row_dir);
                        end
                    end else begin
                        st_row = f_move_row(r_cur_row, r_row_dir);
                        if (e_ge) begin
                            st_col = f_move_col(r_cur_col, r_col_dir);
                        end
                    end
                    n_err = r_err - (e_ge ? ERR_W'(r_major_twice) : '0)
                            + ERR_W'(r_minor_twice);
                    n_steps_left = r_steps_left - COORD_W'(1);
                    n_cur_row    = st_row;
                    n_cur_col    = st_col;
                    if (st_col != r_cur_col || f_page(st_row) != f_page(r_cur_row)) begin
                        o_push.count = 2'd2;
                        o_push.res0  = f_data(r_pixel_byte, 1'b0);
                        o_push.res1  = f_pos(f_page(st_row), COORD_W'(st_col));
                        n_pixel_byte = f_bit(st_row);
                    end else begin
                        n_pixel_byte = r_pixel_byte | f_bit(st_row);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_active   <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_opcode    <= i_opcode;
            r_row_start <= i_row_start;
            r_col_start <= i_col_start;
            r_row_end   <= i_row_end;
            r_col_end   <= i_col_end;
        end
        r_cur_row      <= n_cur_row;
        r_cur_col      <= n_cur_col;
        r_row_dir      <= n_row_dir;
        r_col_dir      <= n_col_dir;
        r_major_is_col <= n_major_is_col;
        r_err          <= n_err;
        r_minor_twice  <= n_minor_twice;
        r_major_twice  <= n_major_twice;
        r_steps_left   <= n_steps_left;
        r_pixel_byte   <= n_pixel_byte;
    end

endmodule

>>> hw/rtl/plr_fifo.sv
// Result queue: takes up to two results per cycle, delivers one per cycle while the output is ready.
`timescale 1ns / 1ps

module plr_fifo import plr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    t_result             r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic                pop;
    logic [Q_PTR_W-1:0]  wr_ptr1;

    assign o_out_valid = r_count != '0;
    assign o_result    = r_q[r_rd_ptr];
    assign pop         = o_out_valid && i_out_ready;
    assign o_room      = r_count <= Q_CNT_W'(Q_DEPTH - 2);
    assign wr_ptr1     = r_wr_ptr + Q_PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + Q_PTR_W'(i_push.count);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= r_count + Q_CNT_W'(i_push.count) - Q_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_q[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_q[wr_ptr1] <= i_push.res1;
        end
    end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the page-mode line rasterizer.
`timescale 1ns / 1ps

module tb_top;
    import plr_pkg::*;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] r0;
        logic [COORD_W-1:0] c0;
        logic [COORD_W-1:0] r1;
        logic [COORD_W-1:0] c1;
    } t_line_cmd;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    t_line_cmd cur_cmd = '0;

    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_kind;
    logic [PAGE_W-1:0]  o_page;
    logic [COORD_W-1:0] o_column;
    logic [PIX_W-1:0]   o_pixels;
    logic               o_last;

    t_line_cmd pending_cmds[$];
    t_result   expected_results[$];
    int        send_idle = 0;
    int        recv_idle = 0;
    int        errors = 0;
    int        stim_count = 0;

    // shadow of the rasterizer state
    logic               ln_active = 1'b0;
    logic [COORD_W-1:0] ln_row = '0;
    logic [COORD_W-1:0] ln_col = '0;
    t_dir               ln_row_dir = DIR_NONE;
    t_dir               ln_col_dir = DIR_NONE;
    logic               ln_major_col = 1'b0;
    int                 ln_err = 0;
    int                 ln_minor2 = 0;
    int                 ln_major2 = 0;
    int                 ln_steps = 0;
    logic [PIX_W-1:0]   ln_byte = '0;

    page_mode_line_rasterizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (cur_cmd.op),
        .i_row_start (cur_cmd.r0),
        .i_col_start (cur_cmd.c0),
        .i_row_end   (cur_cmd.r1),
        .i_col_end   (cur_cmd.c1),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_kind      (o_kind),
        .o_page      (o_page),
        .o_column    (o_column),
        .o_pixels    (o_pixels),
        .o_last      (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result pos_result(input logic [COORD_W-1:0] row,
                                           input logic [COORD_W-1:0] col);
        t_result r;
        r.kind   = KIND_POS;
        r.page   = row[COORD_W-1:PAGE_SHIFT];
        r.column = col;
        r.pixels = '0;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic t_result data_result(input logic [PIX_W-1:0] pix, input logic fin);
        t_result r;
        r.kind   = KIND_DATA;
        r.page   = '0;
        r.column = '0;
        r.pixels = pix;
        r.last   = fin;
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] v, input t_dir d);
        if (d == DIR_INC)
            return v + COORD_W'(1);
        if (d == DIR_DEC)
            return v - COORD_W'(1);
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] row_mask(input logic [COORD_W-1:0] row);
        return PIX_W'(1) << row[PAGE_SHIFT-1:0];
    endfunction

    task automatic rasterize_cmd(input t_line_cmd c);
        int dr, dc, major, minor;
        logic [COORD_W-1:0] prev_row, prev_col;
        if (c.op == OP_START) begin
            dr = int'(c.r1) - int'(c.r0);
            dc = int'(c.c1) - int'(c.c0);
            ln_row_dir = dr > 0 ? DIR_INC : (dr < 0 ? DIR_DEC : DIR_NONE);
            ln_col_dir = dc > 0 ? DIR_INC : (dc < 0 ? DIR_DEC : DIR_NONE);
            if (dr < 0) dr = -dr;
            if (dc < 0) dc = -dc;
            ln_major_col = dr < dc;
            major = ln_major_col ? dc : dr;
            minor = ln_major_col ? dr : dc;
            ln_minor2 = 2 * minor;
            ln_major2 = 2 * major;
            ln_err = ln_minor2 - major;
            ln_steps = major;
            ln_row = c.r0;
            ln_col = c.c0;
            ln_byte = row_mask(c.r0);
            ln_active = 1'b1;
            expected_results.push_back(pos_result(ln_row, ln_col));
        end else if (ln_active) begin
            if (ln_steps == 0) begin
                expected_results.push_back(data_result(ln_byte, 1'b1));
                ln_active = 1'b0;
            end else begin
                prev_row = ln_row;
                prev_col = ln_col;
                if (ln_err >= 0) begin
                    if (ln_major_col)
                        ln_row = nudge(ln_row, ln_row_dir);
                    else
                        ln_col = nudge(ln_col, ln_col_dir);
                    ln_err -= ln_major2;
                end
                if (ln_major_col)
                    ln_col = nudge(ln_col, ln_col_dir);
                else
                    ln_row = nudge(ln_row, ln_row_dir);
                ln_err += ln_minor2;
                ln_steps--;
                if (ln_col != prev_col ||
                    ln_row[COORD_W-1:PAGE_SHIFT] != prev_row[COORD_W-1:PAGE_SHIFT]) begin
                    expected_results.push_back(data_result(ln_byte, 1'b0));
                    expected_results.push_back(pos_result(ln_row, ln_col));
                    ln_byte = row_mask(ln_row);
                end else begin
                    ln_byte |= row_mask(ln_row);
                end
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin : drive_proc
        logic      take;
        t_line_cmd nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            take = !in_valid || o_in_ready;
            if (in_valid && o_in_ready)
                rasterize_cmd(cur_cmd);
            if (take) begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    nxt = pending_cmds.pop_front();
                    cur_cmd  <= nxt;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    function automatic int field_bad(input string name, input int e, input int a);
        if (e != a) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
            return 1;
        end
        return 0;
    endfunction

    // monitor
    always @(posedge i_clk) begin : mon_proc
        t_result e;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected transaction: expected none, actual kind %0h",
                             $time, o_kind);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    errors += field_bad("kind", e.kind, o_kind);
                    errors += field_bad("page", e.page, o_page);
                    errors += field_bad("column", e.column, o_column);
                    errors += field_bad("pixels", e.pixels, o_pixels);
                    errors += field_bad("last", e.last, o_last);
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic push_cmd(input logic op, input int r0, input int c0, input int r1,
                            input int c1, input bit counted);
        t_line_cmd c;
        c.op = op;
        c.r0 = COORD_W'(r0);
        c.c0 = COORD_W'(c0);
        c.r1 = COORD_W'(r1);
        c.c1 = COORD_W'(c1);
        pending_cmds.push_back(c);
        if (counted)
            stim_count++;
    endtask

    task automatic push_steps(input int n, input bit counted);
        for (int i = 0; i < n; i++)
            push_cmd(OP_STEP, $urandom, $urandom, $urandom, $urandom, counted);
    endtask

    task automatic directed_lines();
        push_steps(1, 1'b0);
        push_cmd(OP_START, 0, 0, 0, 0, 1'b1);
        push_steps(1, 1'b1);
        push_cmd(OP_START, 127, 127, 0, 0, 1'b1);
        push_steps(3, 1'b1);
        push_cmd(OP_START, 5, 0, 10, 2, 1'b1);
        push_steps(6, 1'b1);
        push_cmd(OP_START, 127, 0, 127, 3, 1'b1);
        push_steps(4, 1'b1);
        push_steps(1, 1'b0);
    endtask

    function automatic int near_coord(input int v);
        int lo, hi;
        lo = v - 12 < 0 ? 0 : v - 12;
        hi = v + 12 > 127 ? 127 : v + 12;
        return $urandom_range(lo, hi);
    endfunction

    task automatic random_lines(input int target);
        int r0, c0, r1, c1, dr, dc, major, n;
        bit idle_now;
        idle_now = 1'b0;
        while (stim_count < target) begin
            if (idle_now && $urandom_range(0, 99) < 5)
                push_steps($urandom_range(1, 2), 1'b0);
            r0 = $urandom_range(0, 127);
            c0 = $urandom_range(0, 127);
            if ($urandom_range(0, 99) < 75) begin
                r1 = near_coord(r0);
                c1 = near_coord(c0);
            end else begin
                r1 = $urandom_range(0, 127);
                c1 = $urandom_range(0, 127);
            end
            dr = r1 > r0 ? r1 - r0 : r0 - r1;
            dc = c1 > c0 ? c1 - c0 : c0 - c1;
            major = dr > dc ? dr : dc;
            push_cmd(OP_START, r0, c0, r1, c1, 1'b1);
            if ($urandom_range(0, 99) < 10) begin
                n = $urandom_range(0, major);
                push_steps(n, 1'b1);
                idle_now = 1'b0;
            end else begin
                push_steps(major + 1, 1'b1);
                idle_now = 1'b1;
                if ($urandom_range(0, 99) < 10)
                    push_steps($urandom_range(1, 3), 1'b0);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = phase == 0 ? 31 : (phase == 1 ? 71 : 0);
            recv_idle = phase == 0 ? 71 : (phase == 1 ? 31 : 0);
            if (phase == 0)
                directed_lines();
            random_lines(stim_count + 670);
            while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
                @(posedge i_clk);
            repeat (4) @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/plr_pkg.sv
hw/rtl/plr_step.sv
hw/rtl/plr_fifo.sv
hw/rtl/page_mode_line_rasterizer.sv
tb/tb_top.sv
